FILE: hdl/rsm_pkg.sv
// ----------------------------------------------------------------------------
// rsm_pkg
// types and constants shared by the rotor speed mixer
// ----------------------------------------------------------------------------
package rsm_pkg;

	localparam int COEF_BITS = 16;
	localparam int DATA_BITS = 32;
	localparam int LANE_BITS = 16;
	localparam int ROWS = 4;
	localparam int COLS = 4;
	localparam int PROD_BITS = COEF_BITS + DATA_BITS;
	localparam int SUM_BITS = PROD_BITS + 2;
	localparam int RAD_BITS = 64;
	localparam int ROOT_BITS = RAD_BITS / 2;
	localparam int SQ_STEPS = 4;
	localparam int SQ_STAGES = ROOT_BITS / SQ_STEPS;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 64;

	localparam logic [CFG_IDX_BITS-1:0] REG_ROW0 = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_ROW1 = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_ROW2 = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_ROW3 = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_SHIFT = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX = 3'd5;

	typedef struct packed {
		logic signed [31:0] moment_z;
		logic signed [31:0] moment_y;
		logic signed [31:0] moment_x;
		logic signed [31:0] thrust;
	} in_word_t;

	typedef struct packed {
		logic [15:0] speed_three;
		logic [15:0] speed_two;
		logic [15:0] speed_one;
		logic [15:0] speed_zero;
	} out_word_t;

	typedef struct packed {
		logic [RAD_BITS-1:0] x;
		logic [RAD_BITS-1:0] root;
	} sq_state_t;

	// one bit-pair step of the digit-by-digit square root; j is the bit pair
	function automatic sq_state_t sq_step(sq_state_t s, int j);
		sq_state_t r;
		logic [RAD_BITS-1:0] bitv;
		logic [RAD_BITS-1:0] t;
		bitv = RAD_BITS'(1) << (2 * j);
		t = s.root + bitv;
		r = s;
		if (s.x >= t) begin
			r.x = s.x - t;
			r.root = (s.root >> 1) + bitv;
		end else begin
			r.root = s.root >> 1;
		end
		return r;
	endfunction

endpackage

FILE: hdl/rsm_isqrt.sv
// ----------------------------------------------------------------------------
// rsm_isqrt
// pipelined floor square root of a 64-bit radicand with clamp
// ----------------------------------------------------------------------------
module rsm_isqrt (
	input  logic                          clk,
	input  logic                          en,
	input  logic                          neg,
	input  logic [rsm_pkg::RAD_BITS-1:0]  rad,
	input  logic [15:0]                   max_speed,
	output logic [15:0]                   speed
);

	rsm_pkg::sq_state_t nx[rsm_pkg::SQ_STAGES];
	rsm_pkg::sq_state_t st_s[rsm_pkg::SQ_STAGES];
	logic               neg_s[rsm_pkg::SQ_STAGES];

	always_comb begin
		nx[0].x = rad;
		nx[0].root = '0;
		for (int k = 0; k < rsm_pkg::SQ_STEPS; k++)
			nx[0] = rsm_pkg::sq_step(nx[0], rsm_pkg::ROOT_BITS - 1 - k);
		for (int g = 1; g < rsm_pkg::SQ_STAGES; g++) begin
			nx[g] = st_s[g-1];
			for (int k = 0; k < rsm_pkg::SQ_STEPS; k++)
				nx[g] = rsm_pkg::sq_step(nx[g],
					rsm_pkg::ROOT_BITS - 1 - g * rsm_pkg::SQ_STEPS - k);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s[0] <= neg;
			for (int g = 0; g < rsm_pkg::SQ_STAGES; g++)
				st_s[g] <= nx[g];
			for (int g = 1; g < rsm_pkg::SQ_STAGES; g++)
				neg_s[g] <= neg_s[g-1];
		end
	end

	always_comb begin
		if (neg_s[rsm_pkg::SQ_STAGES-1])
			speed = '0;
		else if (st_s[rsm_pkg::SQ_STAGES-1].root >= {48'd0, max_speed})
			speed = max_speed;
		else
			speed = st_s[rsm_pkg::SQ_STAGES-1].root[15:0];
	end

endmodule

FILE: hdl/rotor_speed_mixer.sv
// ----------------------------------------------------------------------------
// rotor_speed_mixer
// quadrotor mixer: 4x4 matrix product, shift, square root and clamp
// ----------------------------------------------------------------------------
// pipeline: input, product and row-sum registers, square-root stages and the output register (12 stages total)
// throughput: one word per cycle while no stall holds the pipeline; every stage is a register, nothing iterates
// a stall freezes the whole pipeline; reset clears valid bits and registers
// to coefficients 0, sum_shift 16, max_speed 65535
module rotor_speed_mixer (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  rsm_pkg::in_word_t                  in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output rsm_pkg::out_word_t                 out_data,
	input  logic                               cfg_we,
	input  logic [rsm_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [rsm_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int NV = 3 + rsm_pkg::SQ_STAGES + 1;

	logic [63:0] row_q[rsm_pkg::ROWS];
	logic [5:0]  shift_q;
	logic [15:0] max_q;
	logic [NV-1:0] vld_q;
	logic        en;

	assign en = !(out_valid && out_stall);
	assign in_stall = !en;
	assign out_valid = vld_q[NV-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < rsm_pkg::ROWS; r++) row_q[r] <= '0;
			shift_q <= 6'd16;
			max_q <= 16'hFFFF;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rsm_pkg::REG_ROW0: row_q[0] <= cfg_data;
				rsm_pkg::REG_ROW1: row_q[1] <= cfg_data;
				rsm_pkg::REG_ROW2: row_q[2] <= cfg_data;
				rsm_pkg::REG_ROW3: row_q[3] <= cfg_data;
				rsm_pkg::REG_SHIFT: shift_q <= cfg_data[5:0];
				rsm_pkg::REG_MAX: max_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[NV-2:0], in_valid};
	end

	// stage 1: input register
	logic signed [rsm_pkg::DATA_BITS-1:0] vec_s1[rsm_pkg::COLS];
	always_ff @(posedge clk) begin
		if (en) begin
			vec_s1[0] <= in_data.thrust[rsm_pkg::DATA_BITS-1:0];
			vec_s1[1] <= in_data.moment_x[rsm_pkg::DATA_BITS-1:0];
			vec_s1[2] <= in_data.moment_y[rsm_pkg::DATA_BITS-1:0];
			vec_s1[3] <= in_data.moment_z[rsm_pkg::DATA_BITS-1:0];
		end
	end

	// stage 2: products
	logic signed [rsm_pkg::PROD_BITS-1:0] prod_s2[rsm_pkg::ROWS][rsm_pkg::COLS];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < rsm_pkg::ROWS; r++)
				for (int c = 0; c < rsm_pkg::COLS; c++)
					prod_s2[r][c] <= $signed(row_q[r][c*rsm_pkg::LANE_BITS +:
						rsm_pkg::COEF_BITS]) * vec_s1[c];
		end
	end

	// stage 3: row sums and shift
	logic [rsm_pkg::RAD_BITS-1:0] rad_s3[rsm_pkg::ROWS];
	logic                         neg_s3[rsm_pkg::ROWS];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < rsm_pkg::ROWS; r++) begin
				logic signed [rsm_pkg::SUM_BITS-1:0] acc;
				acc = '0;
				for (int c = 0; c < rsm_pkg::COLS; c++)
					acc = acc + rsm_pkg::SUM_BITS'(prod_s2[r][c]);
				neg_s3[r] <= acc[rsm_pkg::SUM_BITS-1];
				rad_s3[r] <= rsm_pkg::RAD_BITS'($unsigned(acc)) >> shift_q;
			end
		end
	end

	logic [15:0] spd[rsm_pkg::ROWS];
	for (genvar r = 0; r < rsm_pkg::ROWS; r++) begin : g_row
		rsm_isqrt u_sq (
			.clk(clk), .en(en),
			.neg(neg_s3[r]), .rad(rad_s3[r]), .max_speed(max_q), .speed(spd[r])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data.speed_zero <= spd[0];
			out_data.speed_one <= spd[1];
			out_data.speed_two <= spd[2];
			out_data.speed_three <= spd[3];
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output changed under stall");
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall mismatch");
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall && in_valid |=> vld_q[0])
		else $error("accepted word lost");

endmodule

FILE: sim/tb_rotor_speed_mixer.sv
// ----------------------------------------------------------------------------
// tb_rotor_speed_mixer
// drives random and directed command words through the rotor speed mixer
// across several register settings and checks every speed word against a
// behavioral model of the matrix product, shift, square root and clamp
// ----------------------------------------------------------------------------
module tb_rotor_speed_mixer;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid = 1'b0;
	logic in_stall;
	rsm_pkg::in_word_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	rsm_pkg::out_word_t out_data;
	logic cfg_we = 1'b0;
	logic [rsm_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [rsm_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

	rotor_speed_mixer uut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	logic [63:0] mix_rows[4];
	logic [5:0] shift_amt;
	logic [15:0] speed_cap;
	rsm_pkg::in_word_t pending_words[$];
	rsm_pkg::out_word_t expected_speeds[$];
	int mismatches = 0;
	int gap_left = 0;
	int stall_left = 0;
	bit hold_off = 1'b0;

	function automatic logic [15:0] floor_sqrt(logic [63:0] x);
		logic [63:0] root;
		logic [63:0] b;
		root = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= root + b) begin
				x = x - (root + b);
				root = (root >> 1) + b;
			end else begin
				root = root >> 1;
			end
			b = b >> 2;
		end
		return (root > 64'hFFFF) ? 16'hFFFF : root[15:0];
	endfunction

	function automatic rsm_pkg::out_word_t mix_speeds(rsm_pkg::in_word_t w);
		logic signed [63:0] v[4];
		logic signed [63:0] acc;
		logic signed [15:0] coef;
		logic [63:0] root;
		logic [15:0] sp[4];
		rsm_pkg::out_word_t o;
		v[0] = w.thrust;
		v[1] = w.moment_x;
		v[2] = w.moment_y;
		v[3] = w.moment_z;
		for (int r = 0; r < 4; r++) begin
			acc = 0;
			for (int c = 0; c < 4; c++) begin
				coef = mix_rows[r][16*c +: 16];
				acc += 64'(coef) * v[c];
			end
			if (acc < 0) begin
				sp[r] = 16'd0;
			end else begin
				root = {48'd0, floor_sqrt(64'(acc) >> shift_amt)};
				if (64'(acc) >> shift_amt >= 64'h1_0000_0000) root = 64'h1_0000;
				sp[r] = (root >= speed_cap) ? speed_cap : root[15:0];
			end
		end
		o.speed_zero = sp[0];
		o.speed_one = sp[1];
		o.speed_two = sp[2];
		o.speed_three = sp[3];
		return o;
	endfunction

	function automatic int rand_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_speeds.push_back(mix_speeds(in_data));
				void'(pending_words.pop_front());
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_words.size() != 0 && !hold_off) begin
					in_valid <= 1'b1;
					in_data <= pending_words[0];
					gap_left <= rand_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_speeds.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected word %h", out_data);
				end else begin
					if (out_data !== expected_speeds[0]) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %h actual %h",
								expected_speeds[0], out_data);
					end
					void'(expected_speeds.pop_front());
				end
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				stall_left <= rand_gap();
			end
		end
	end

	task automatic write_reg(logic [rsm_pkg::CFG_IDX_BITS-1:0] idx, logic [63:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx <= rsm_pkg::REG_ROW3) mix_rows[idx[1:0]] = val;
		else if (idx == rsm_pkg::REG_SHIFT) shift_amt = val[5:0];
		else if (idx == rsm_pkg::REG_MAX) speed_cap = val[15:0];
	endtask

	task automatic drain();
		while (pending_words.size() != 0 || in_valid || expected_speeds.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_field(int mode);
		case (mode)
			0: return $urandom;
			1: return $urandom_range(0, 32'h0040_0000);
			2: return -$urandom_range(0, 32'h0004_0000);
			default: return $urandom_range(0, 32'h0010_0000);
		endcase
	endfunction

	function automatic rsm_pkg::in_word_t rand_word();
		rsm_pkg::in_word_t w;
		int m;
		m = $urandom_range(0, 3);
		w.thrust = rand_field(m == 0 ? 0 : 1);
		w.moment_x = rand_field(m == 0 ? 0 : 2 + $urandom_range(0, 1));
		w.moment_y = rand_field(m == 0 ? 0 : 2 + $urandom_range(0, 1));
		w.moment_z = rand_field(m == 0 ? 0 : 2 + $urandom_range(0, 1));
		return w;
	endfunction

	function automatic logic [63:0] rand_row();
		logic [63:0] r;
		r = {$urandom, $urandom};
		if ($urandom_range(0, 2) != 0)
			for (int c = 0; c < 4; c++)
				r[16*c +: 16] = 16'($signed($urandom_range(0, 400)) - 100);
		return r;
	endfunction

	function automatic rsm_pkg::in_word_t mk(logic [31:0] t, logic [31:0] x,
		logic [31:0] y, logic [31:0] z);
		rsm_pkg::in_word_t w;
		w.thrust = t;
		w.moment_x = x;
		w.moment_y = y;
		w.moment_z = z;
		return w;
	endfunction

	initial begin
		arst_n = 1'b0;
		for (int r = 0; r < 4; r++) mix_rows[r] = '0;
		shift_amt = 6'd16;
		speed_cap = 16'hFFFF;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		// defaults: all zero coefficients
		pending_words.push_back(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 0));
		drain();
		// extremes of coefficients
		write_reg(rsm_pkg::REG_ROW0, 64'h7FFF_7FFF_7FFF_7FFF);
		write_reg(rsm_pkg::REG_ROW1, 64'h8000_8000_8000_8000);
		write_reg(rsm_pkg::REG_ROW2, 64'h0001_FFFF_0001_FFFF);
		write_reg(rsm_pkg::REG_ROW3, 64'h0000_0000_0000_0001);
		write_reg(rsm_pkg::REG_SHIFT, 64'd0);
		write_reg(rsm_pkg::REG_MAX, 64'hFFFF);
		pending_words.push_back(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF));
		pending_words.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000));
		pending_words.push_back(mk(32'hFFFF_FFFF, 0, 0, 0));
		pending_words.push_back(mk(32'h0001_0000, 32'h0000_0001, 0, 0));
		pending_words.push_back(mk(0, 0, 0, 0));
		pending_words.push_back(mk(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
			32'hAAAA_AAAA));
		drain();
		write_reg(rsm_pkg::REG_SHIFT, 64'd63);
		write_reg(rsm_pkg::REG_MAX, 64'd0);
		pending_words.push_back(mk(32'h7FFF_FFFF, 0, 0, 0));
		pending_words.push_back(mk(32'h8000_0000, 0, 0, 0));
		drain();
		write_reg(rsm_pkg::REG_SHIFT, 64'd47);
		write_reg(rsm_pkg::REG_MAX, 64'd100);
		// indexes past the last register are ignored
		write_reg(3'd6, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(3'd7, 64'd1);
		pending_words.push_back(mk(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h1234_5678));
		pending_words.push_back(mk(32'h0100_0000, 32'h0000_0000, 32'hFFFF_0000,
			32'h7FFF_FFFF));
		drain();
		for (int ph = 0; ph < 10; ph++) begin
			for (int r = 0; r < 4; r++)
				write_reg(rsm_pkg::CFG_IDX_BITS'(r), rand_row());
			write_reg(rsm_pkg::REG_SHIFT, 64'($urandom_range(0, 63)));
			write_reg(rsm_pkg::REG_MAX, $urandom_range(0, 3) == 0 ?
				64'($urandom_range(0, 65535)) : 64'hFFFF);
			for (int i = 0; i < 195; i++) begin
				pending_words.push_back(rand_word());
				if (i == 100 && ph == 3) begin
					while (pending_words.size() != 0 || in_valid) @(posedge clk);
					hold_off = 1'b1;
					while (expected_speeds.size() != 0) @(posedge clk);
					hold_off = 1'b0;
				end
				if (pending_words.size() > 8) @(posedge clk);
			end
			drain();
		end
		if (mismatches == 0 && expected_speeds.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: rotor_speed_mixer.f
hdl/rsm_pkg.sv
hdl/rsm_isqrt.sv
hdl/rotor_speed_mixer.sv
sim/tb_rotor_speed_mixer.sv
